/* hdl/rbsi_pkg.sv */
// shared types, widths and helper functions for the ray/box slab intersection pipeline
// no dependencies
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int DIFF_W    = IN_W + 1;
  localparam int NUM_W     = DIFF_W + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int TW        = 52;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;

  localparam logic signed [TW-1:0] T_INF = TW'(64'sd1 <<< 50);
  localparam logic signed [TW-1:0] T_MAX = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] T_MIN = -TW'(64'sd2147483648);

  typedef struct packed {
    logic [IN_W-1:0]  rem;
    logic [NUM_W-1:0] nq;
    logic [IN_W-1:0]  dv;
    logic             neg;
  } rbsi_lane_t;

  typedef struct packed {
    logic zero;
    logic in_slab;
  } rbsi_axis_t;

  typedef struct packed {
    rbsi_lane_t [LANES-1:0] lane;
    rbsi_axis_t [AXES-1:0]  ax;
  } rbsi_div_t;

  // one restoring division step: shift in the next numerator bit, try subtract
  function automatic rbsi_lane_t div_step(input rbsi_lane_t l);
    rbsi_lane_t      r;
    logic [IN_W:0]   sh;
    logic [IN_W+1:0] tr;
    r  = l;
    sh = {l.rem, l.nq[NUM_W-1]};
    tr = {1'b0, sh} - {2'b00, l.dv};
    r.nq = {l.nq[NUM_W-2:0], 1'b0};
    if (!tr[IN_W+1]) begin
      r.rem   = tr[IN_W-1:0];
      r.nq[0] = 1'b1;
    end else begin
      r.rem = sh[IN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] sat32(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] c;
    c = v;
    if (v > T_MAX) c = T_MAX;
    if (v < T_MIN) c = T_MIN;
    return c[IN_W-1:0];
  endfunction

endpackage

/* hdl/ray_box_slab_intersect_top.sv */
// ray versus axis-aligned box slab test, signed q16.16, fully pipelined
// throughput one item per cycle while the output register is empty or taken
// six 49-step restoring dividers (one bit per stage) set the depth
// the whole pipeline advances when the output register is empty or taken
// rst is synchronous: it clears all valid bits, payload is not reset
// depends on rbsi_pkg
module ray_box_slab_intersect_top
  import rbsi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z, 32 bits each from bit 0
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // t_near [31:0], t_far [63:32]
  output logic [63:0]  m_tdata,
  // hit
  output logic [0:0]   m_tuser
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rbsi_div_t div_in;
  rbsi_div_t div_q  [DIV_STEPS+1];
  logic      div_vld[DIV_STEPS+1];

  always_comb begin
    logic [IN_W-1:0]   o, d, bmin, bmax;
    logic [DIFF_W-1:0] diff, mag;
    logic [IN_W-1:0]   dmag;
    div_in = '0;
    for (int a = 0; a < AXES; a++) begin
      o    = s_tdata[32*a +: 32];
      d    = s_tdata[96 + 32*a +: 32];
      bmin = s_tdata[192 + 32*a +: 32];
      bmax = s_tdata[288 + 32*a +: 32];
      dmag = d[IN_W-1] ? -d : d;
      div_in.ax[a].zero    = (d == '0);
      div_in.ax[a].in_slab = ($signed(bmin) <= $signed(o)) && ($signed(o) <= $signed(bmax));
      for (int k = 0; k < 2; k++) begin
        diff = (k == 0) ? ({bmin[IN_W-1], bmin} - {o[IN_W-1], o})
                        : ({bmax[IN_W-1], bmax} - {o[IN_W-1], o});
        mag  = diff[DIFF_W-1] ? -diff : diff;
        div_in.lane[2*a+k].rem = '0;
        div_in.lane[2*a+k].nq  = {mag, {FRAC_BITS{1'b0}}};
        div_in.lane[2*a+k].dv  = dmag;
        div_in.lane[2*a+k].neg = diff[DIFF_W-1] ^ d[IN_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else if (en) begin
      div_vld[0] <= s_tvalid;
    end
    if (en) begin
      div_q[0] <= div_in;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rbsi_div_t nxt;
    always_comb begin
      nxt = div_q[i];
      for (int l = 0; l < LANES; l++) begin
        nxt.lane[l] = div_step(div_q[i].lane[l]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[i+1] <= 1'b0;
      end else if (en) begin
        div_vld[i+1] <= div_vld[i];
      end
      if (en) begin
        div_q[i+1] <= nxt;
      end
    end
  end

  // signed quotients, ordered per axis
  logic signed [TW-1:0] ord_lo[AXES], ord_hi[AXES], ord_lo_next[AXES], ord_hi_next[AXES];
  logic [AXES-1:0]      ord_ok, ord_ok_next;
  logic                 ord_vld;

  always_comb begin
    logic signed [TW-1:0] ta, tb;
    for (int a = 0; a < AXES; a++) begin
      ta = TW'({3'b000, div_q[DIV_STEPS].lane[2*a].nq});
      tb = TW'({3'b000, div_q[DIV_STEPS].lane[2*a+1].nq});
      if (div_q[DIV_STEPS].lane[2*a].neg)   ta = -ta;
      if (div_q[DIV_STEPS].lane[2*a+1].neg) tb = -tb;
      if (div_q[DIV_STEPS].ax[a].zero) begin
        ord_lo_next[a] = -T_INF;
        ord_hi_next[a] = T_INF;
        ord_ok_next[a] = div_q[DIV_STEPS].ax[a].in_slab;
      end else begin
        ord_lo_next[a] = (ta > tb) ? tb : ta;
        ord_hi_next[a] = (ta > tb) ? ta : tb;
        ord_ok_next[a] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ord_vld <= 1'b0;
    end else if (en) begin
      ord_vld <= div_vld[DIV_STEPS];
    end
    if (en) begin
      ord_lo <= ord_lo_next;
      ord_hi <= ord_hi_next;
      ord_ok <= ord_ok_next;
    end
  end

  // x and y intervals merged
  logic signed [TW-1:0] xy_tn, xy_tf, xy_tn_next, xy_tf_next, z_lo, z_hi;
  logic                 xy_ok, xy_ok_next, z_ok, xy_vld;

  always_comb begin
    xy_ok_next = ord_ok[0] && ord_ok[1] &&
                 !(ord_lo[0] > ord_hi[1]) && !(ord_lo[1] > ord_hi[0]);
    xy_tn_next = (ord_lo[0] < ord_lo[1]) ? ord_lo[1] : ord_lo[0];
    xy_tf_next = (ord_hi[0] > ord_hi[1]) ? ord_hi[1] : ord_hi[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_vld <= 1'b0;
    end else if (en) begin
      xy_vld <= ord_vld;
    end
    if (en) begin
      xy_tn <= xy_tn_next;
      xy_tf <= xy_tf_next;
      xy_ok <= xy_ok_next;
      z_lo  <= ord_lo[2];
      z_hi  <= ord_hi[2];
      z_ok  <= ord_ok[2];
    end
  end

  // z interval merged, saturated, output register
  logic                 hit_next;
  logic signed [TW-1:0] tn_fin, tf_fin;
  logic [63:0]          tdata_next;

  always_comb begin
    hit_next = xy_ok && z_ok && !(xy_tn > z_hi) && !(z_lo > xy_tf);
    tn_fin   = (xy_tn < z_lo) ? z_lo : xy_tn;
    tf_fin   = (xy_tf > z_hi) ? z_hi : xy_tf;
    tdata_next = hit_next ? {sat32(tf_fin), sat32(tn_fin)} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= xy_vld;
    end
    if (en) begin
      m_tdata    <= tdata_next;
      m_tuser[0] <= hit_next;
    end
  end

endmodule

/* hdl/rbsi_checker.sv */
// port-level checks for the ray/box slab intersection pipeline, bound to the top level
// depends on ray_box_slab_intersect_top
module rbsi_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
    else $error("miss item with nonzero parameters");

  a_near_le_far: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> $signed(m_tdata[31:0]) <= $signed(m_tdata[63:32]))
    else $error("hit item with near above far");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready not tied to output drain");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output item changed");

endmodule

bind ray_box_slab_intersect_top rbsi_checker u_rbsi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* test/ray_box_slab_intersect_top_tb.sv */
// testbench for ray_box_slab_intersect_top: directed and random ray/box items
// predicts hit, t_near and t_far per item and checks results in order
// depends on rbsi_pkg and ray_box_slab_intersect_top
`timescale 1ns / 1ps

class slab_hit_board;
  logic [64:0] pending_hits[$];
  int fails;

  function automatic logic signed [63:0] sx(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // predicted {hit, t_far, t_near}
  function automatic logic [64:0] trace(input logic [383:0] d);
    logic signed [63:0] o, dr, bl, bh, lo, hi, tn, tf, sw;
    logic ok;
    tn = 0;
    tf = 0;
    ok = 1;
    for (int a = 0; a < 3 && ok; a++) begin
      o  = sx(d[32*a +: 32]);
      dr = sx(d[32*(3+a) +: 32]);
      bl = sx(d[32*(6+a) +: 32]);
      bh = sx(d[32*(9+a) +: 32]);
      if (dr == 0) begin
        if (bl <= o && o <= bh) begin
          lo = -(64'sd1 <<< 50);
          hi = 64'sd1 <<< 50;
        end else begin
          ok = 0;
        end
      end else begin
        lo = ((bl - o) * 64'sd65536) / dr;
        hi = ((bh - o) * 64'sd65536) / dr;
        if (lo > hi) begin
          sw = lo;
          lo = hi;
          hi = sw;
        end
      end
      if (ok) begin
        if (a == 0) begin
          tn = lo;
          tf = hi;
        end else if (tn > hi || lo > tf) begin
          ok = 0;
        end else begin
          if (tn < lo) tn = lo;
          if (tf > hi) tf = hi;
        end
      end
    end
    if (!ok) return '0;
    return {1'b1, clip32(tf), clip32(tn)};
  endfunction

  function void note_ray(input logic [383:0] d);
    pending_hits.push_back(trace(d));
  endfunction

  function void check_hit(input logic [63:0] data, input logic u);
    logic [64:0] e;
    if (pending_hits.size() == 0) begin
      $error("unexpected item: hit %0b data %h", u, data);
      fails++;
      return;
    end
    e = pending_hits.pop_front();
    if (e[64] !== u) begin
      $error("hit: expected %0b actual %0b", e[64], u);
      fails++;
    end
    if (e[31:0] !== data[31:0]) begin
      $error("t_near: expected %h actual %h", e[31:0], data[31:0]);
      fails++;
    end
    if (e[63:32] !== data[63:32]) begin
      $error("t_far: expected %h actual %h", e[63:32], data[63:32]);
      fails++;
    end
  endfunction
endclass

module ray_box_slab_intersect_top_tb;
  import rbsi_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [383:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic [0:0] m_tuser;
  int send_idle = 0;
  int recv_idle = 0;
  slab_hit_board board;

  ray_box_slab_intersect_top dut (.*);

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_hit(m_tdata, m_tuser[0]);
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h80000000;
      2: return 32'h7fffffff;
      3: return 0;
      default: return 32'(signed'($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] pick_dir();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 0;
      2: return 32'h80000000;
      3: return 32'(signed'($urandom_range(16)) - 8);
      default: return 32'(signed'($urandom_range(400000)) - 200000);
    endcase
  endfunction

  // sensible boxes mostly, so many rays hit
  function automatic logic [383:0] random_ray();
    logic [383:0] d;
    logic [31:0] p, q;
    for (int a = 0; a < 3; a++) begin
      d[32*a +: 32] = pick_coord();
      d[32*(3+a) +: 32] = pick_dir();
      p = pick_coord();
      q = pick_coord();
      if ($urandom_range(9) != 0 && $signed(p) > $signed(q)) begin
        d[32*(6+a) +: 32] = q;
        d[32*(9+a) +: 32] = p;
      end else begin
        d[32*(6+a) +: 32] = p;
        d[32*(9+a) +: 32] = q;
      end
    end
    if ($urandom_range(3) == 0)
      for (int a = 0; a < 3; a++) begin
        p = d[32*(6+a) +: 32];
        q = d[32*(9+a) +: 32];
        if ($signed(p) <= $signed(q))
          d[32*a +: 32] = 32'($signed(p) + ($signed(q) - $signed(p)) / 2);
      end
    return d;
  endfunction

  task automatic send_ray(input logic [383:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    board.note_ray(d);
  endtask

  task automatic send_axes(input logic [31:0] o, dr, lo, hi);
    logic [383:0] d;
    for (int a = 0; a < 3; a++) begin
      d[32*a +: 32] = o;
      d[32*(3+a) +: 32] = dr;
      d[32*(6+a) +: 32] = lo;
      d[32*(9+a) +: 32] = hi;
    end
    send_ray(d);
  endtask

  initial begin
    int waited;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    send_idle = 36;
    recv_idle = 51;
    // zero direction, origin inside everywhere: unbounded
    send_axes(0, 0, 32'hffff0000, 32'h00010000);
    // zero direction, origin outside
    send_axes(32'h00020000, 0, 32'hffff0000, 32'h00010000);
    // inverted box with zero direction
    send_axes(0, 0, 32'h00010000, 32'hffff0000);
    // inverted box with nonzero direction, then a unit box from origins outside it
    send_axes(0, 32'h00010000, 32'h00010000, 32'hffff0000);
    send_axes(32'hfffb0000, 32'h00010000, 32'hffff0000, 32'h00010000);
    send_axes(32'h00050000, 32'h00010000, 32'hffff0000, 32'h00010000);
    send_axes(32'h00050000, 32'hffff0000, 32'hffff0000, 32'h00010000);
    // saturation extremes
    send_axes(32'h80000000, 1, 32'h7fffffff, 32'h7fffffff);
    send_axes(32'h7fffffff, 1, 32'h80000000, 32'h80000000);
    send_axes(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_axes(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_axes(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_axes(32'h55555555, 32'haaaaaaaa, 32'h33333333, 32'hcccccccc);
    send_ray({12{32'h80000000}});
    send_ray({12{32'h7fffffff}});
    send_ray('1);
    send_ray('0);
    for (int i = 0; i < 1650; i++) begin
      if (i == 550) begin
        send_idle = 51;
        recv_idle = 36;
      end else if (i == 1100) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_ray(random_ray());
    end
    s_tvalid <= 0;
    waited = 0;
    while (board.pending_hits.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (board.fails == 0 && board.pending_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
